// ----- hw/rtl/lpr_pkg.sv -----
// Package for the line pixel rasterizer: coordinate widths, request codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package lpr_pkg;

   // Coordinate width (8..16); ports stay 16 bits: inputs are truncated, outputs sign-extended
   localparam int COORD_BITS = 16;
   localparam int OUT_BITS   = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int CNT_BITS   = $clog2(COORD_BITS);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(COORD_BITS - 1);

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        mag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VERT,
      ST_HORZ,
      ST_DIV,
      ST_GEN
   } state_type;

   typedef enum logic [1:0] {
      KIND_VERT,
      KIND_HORZ,
      KIND_GEN
   } kind_type;

   typedef struct packed {
      logic     load;      // latch a new line from the request fields
      logic     div_step;  // one restoring division step
      logic     emit;      // load the output register and advance the walk
      kind_type pick;      // line kind for the emitted pixel
   } cmd_type;

   typedef struct packed {
      kind_type kind;      // kind of the line in the request fields
      logic     last;      // walk position has reached its end
   } sts_type;

endpackage

// ----- hw/rtl/lpr_dpath.sv -----
// Datapath of the line pixel rasterizer: line registers, restoring divider,
// incremental quotient/remainder walk and the output payload register.
// Depends on lpr_pkg.
module lpr_dpath
   import lpr_pkg::*;
(
   input  logic                        clock,
   input  logic [15:0]                 req_first_x,
   input  logic [15:0]                 req_first_y,
   input  logic [15:0]                 req_second_x,
   input  logic [15:0]                 req_second_y,
   input  logic [7:0]                  req_pen_color,
   input  cmd_type                     cmd,
   output sts_type                     sts,
   output logic signed [OUT_BITS-1:0]  rsp_pixel_x,
   output logic signed [OUT_BITS-1:0]  rsp_pixel_y,
   output logic [7:0]                  rsp_pixel_color,
   output logic                        rsp_last_pixel
);

   coord_type walk_pos_ff, walk_pos_in;
   coord_type walk_end_ff, walk_end_in;
   coord_type fixed_ff, fixed_in;
   coord_type origin_x_ff, origin_x_in;
   coord_type origin_y_ff, origin_y_in;
   mag_type   run_dx_ff, run_dx_in;
   logic      neg_ff, neg_in;
   logic [7:0] color_ff, color_in;
   // divider: quo holds the dividend bits, then |dy| / dx; rem ends as |dy| % dx
   mag_type   quo_ff, quo_in;
   mag_type   rem_ff, rem_in;
   // walk accumulators: floor(k*|dy|/dx) and its remainder
   mag_type   acc_q_ff, acc_q_in;
   mag_type   acc_r_ff, acc_r_in;
   logic signed [OUT_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [7:0] pcol_ff, pcol_in;
   logic      plast_ff, plast_in;

   coord_type ax, ay, bx, by, lx, ly, rx, ry;
   logic signed [DIFF_BITS-1:0] dx_w, dy_w, dy_abs, q_signed, y_sum;
   logic [COORD_BITS:0] trial, r_sum;
   coord_type gen_y;
   logic      last;

   assign ax = coord_type'(req_first_x[COORD_BITS-1:0]);
   assign ay = coord_type'(req_first_y[COORD_BITS-1:0]);
   assign bx = coord_type'(req_second_x[COORD_BITS-1:0]);
   assign by = coord_type'(req_second_y[COORD_BITS-1:0]);

   assign last = walk_pos_ff >= walk_end_ff;

   always_comb begin
      priority if (ax == bx) begin
         sts.kind = KIND_VERT;
      end else if (ay == by) begin
         sts.kind = KIND_HORZ;
      end else begin
         sts.kind = KIND_GEN;
      end
      sts.last = last;
   end

   always_comb begin
      // left endpoint is the walk origin of a general line
      lx = (ax < bx) ? ax : bx;
      ly = (ax < bx) ? ay : by;
      rx = (ax < bx) ? bx : ax;
      ry = (ax < bx) ? by : ay;
      dx_w   = DIFF_BITS'(rx) - DIFF_BITS'(lx);
      dy_w   = DIFF_BITS'(ry) - DIFF_BITS'(ly);
      dy_abs = dy_w[DIFF_BITS-1] ? -dy_w : dy_w;

      trial = {rem_ff, quo_ff[COORD_BITS-1]};
      r_sum = {1'b0, acc_r_ff} + {1'b0, rem_ff};

      q_signed = neg_ff ? -DIFF_BITS'({1'b0, acc_q_ff}) : DIFF_BITS'({1'b0, acc_q_ff});
      y_sum    = DIFF_BITS'(origin_y_ff) + q_signed;
      gen_y    = y_sum[COORD_BITS-1:0];

      walk_pos_in = walk_pos_ff;
      walk_end_in = walk_end_ff;
      fixed_in    = fixed_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      run_dx_in   = run_dx_ff;
      neg_in      = neg_ff;
      color_in    = color_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      acc_q_in    = acc_q_ff;
      acc_r_in    = acc_r_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      pcol_in     = pcol_ff;
      plast_in    = plast_ff;

      if (cmd.load) begin
         color_in    = req_pen_color;
         origin_x_in = lx;
         origin_y_in = ly;
         run_dx_in   = dx_w[COORD_BITS-1:0];
         neg_in      = dy_w[DIFF_BITS-1];
         quo_in      = dy_abs[COORD_BITS-1:0];
         rem_in      = '0;
         acc_q_in    = '0;
         acc_r_in    = '0;
         unique case (sts.kind)
            KIND_VERT: begin
               fixed_in    = ax;
               walk_pos_in = (ay < by) ? ay : by;
               walk_end_in = (ay < by) ? by : ay;
            end
            KIND_HORZ: begin
               fixed_in    = ay;
               walk_pos_in = lx;
               walk_end_in = rx;
            end
            default: begin
               walk_pos_in = lx;
               walk_end_in = rx;
            end
         endcase
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, run_dx_ff}) begin
            rem_in = COORD_BITS'(trial - {1'b0, run_dx_ff});
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[COORD_BITS-1:0];
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b0};
         end
      end

      if (cmd.emit) begin
         unique case (cmd.pick)
            KIND_VERT: begin
               px_in = OUT_BITS'(fixed_ff);
               py_in = OUT_BITS'(walk_pos_ff);
            end
            KIND_HORZ: begin
               px_in = OUT_BITS'(walk_pos_ff);
               py_in = OUT_BITS'(fixed_ff);
            end
            default: begin
               px_in = OUT_BITS'(walk_pos_ff);
               py_in = OUT_BITS'(gen_y);
            end
         endcase
         pcol_in  = color_ff;
         plast_in = last;
         if (!last) begin
            walk_pos_in = walk_pos_ff + coord_type'(1);
            // advance by |dy|/dx per step, carrying when the remainder wraps
            if (r_sum >= {1'b0, run_dx_ff}) begin
               acc_r_in = COORD_BITS'(r_sum - {1'b0, run_dx_ff});
               acc_q_in = acc_q_ff + quo_ff + mag_type'(1);
            end else begin
               acc_r_in = r_sum[COORD_BITS-1:0];
               acc_q_in = acc_q_ff + quo_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_pos_ff <= walk_pos_in;
      walk_end_ff <= walk_end_in;
      fixed_ff    <= fixed_in;
      origin_x_ff <= origin_x_in;
      origin_y_ff <= origin_y_in;
      run_dx_ff   <= run_dx_in;
      neg_ff      <= neg_in;
      color_ff    <= color_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      acc_q_ff    <= acc_q_in;
      acc_r_ff    <= acc_r_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pcol_ff     <= pcol_in;
      plast_ff    <= plast_in;
   end

   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = pcol_ff;
   assign rsp_last_pixel  = plast_ff;

endmodule

// ----- hw/rtl/lpr_ctrl.sv -----
// Controller of the line pixel rasterizer: line state machine, divider step
// counter, request stall and output valid. Depends on lpr_pkg.
module lpr_ctrl
   import lpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = (state_ff == ST_DIV) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      cmd.pick     = KIND_GEN;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_START) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               unique case (sts.kind)
                  KIND_VERT: state_in = ST_VERT;
                  KIND_HORZ: state_in = ST_HORZ;
                  default:   state_in = ST_DIV;
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_GEN;
            end
         end
         ST_VERT, ST_HORZ, ST_GEN: begin
            unique case (state_ff)
               ST_VERT: cmd.pick = KIND_VERT;
               ST_HORZ: cmd.pick = KIND_HORZ;
               default: cmd.pick = KIND_GEN;
            endcase
            if (accept && req_func == FUNC_TICK) begin
               cmd.emit = 1'b1;
               if (sts.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted pixel not presented");

   a_div_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> req_stall)
      else $error("request taken during division");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST) |=> state_ff == ST_GEN)
      else $error("division did not hand over to the walk");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("held pixel overwritten");

endmodule

// ----- hw/rtl/line_pixel_rasterizer.sv -----
// Top level of the line pixel rasterizer: controller plus datapath.
// Depends on lpr_pkg, lpr_ctrl and lpr_dpath.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   func, first_x/y, second_x/y, pen_color
//  rsp      out        rsp_valid/rsp_stall   pixel_x, pixel_y, pixel_color, last_pixel
//
// Ticks run at one item per cycle unless a held pixel stalls them: each tick of a
// running line yields one pixel. A start item of a sloped line (neither vertical
// nor horizontal) is followed by the restoring divider forming |dy|/dx and
// |dy|%dx; req_stall stays high meanwhile. Vertical and horizontal lines skip it.
// Each pixel then advances a quotient/remainder pair, so no division per pixel.
// Reset is synchronous and leaves the engine idle; there is no clearing pass.
// A stalled pixel waits in the output register; the next tick is held off until
// it is taken or is taken in the same cycle.
module line_pixel_rasterizer
   import lpr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic signed [15:0]         req_first_x,
   input  logic signed [15:0]         req_first_y,
   input  logic signed [15:0]         req_second_x,
   input  logic signed [15:0]         req_second_y,
   input  logic [7:0]                 req_pen_color,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_pixel_x,
   output logic signed [OUT_BITS-1:0] rsp_pixel_y,
   output logic [7:0]                 rsp_pixel_color,
   output logic                       rsp_last_pixel
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: start/tick decode, divider count, output valid
   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // line registers, divider and pixel payload
   lpr_dpath u_dpath (
      .clock           (clock),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_pen_color   (req_pen_color),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
